// ----- hdl/rfwt_pkg.sv -----
// Shared types, constants and helpers of the range frame wall tracker.
package rfwt_pkg;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes (word address bits [4:2])
  localparam logic [2:0] REG_OPEN_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_MIN_CLEARANCE  = 3'd1;
  localparam logic [2:0] REG_CLEAR_HYST     = 3'd2;
  localparam logic [2:0] REG_WALL_NEAR      = 3'd3;
  localparam logic [2:0] REG_FOLLOW_TARGET  = 3'd4;

  // Register reset values, 1/16 cm
  localparam logic [15:0] RST_OPEN_THRESHOLD = 16'd192;
  localparam logic [15:0] RST_MIN_CLEARANCE  = 16'd64;
  localparam logic [15:0] RST_CLEAR_HYST     = 16'd12;
  localparam logic [15:0] RST_WALL_NEAR      = 16'd160;
  localparam logic [15:0] RST_FOLLOW_TARGET  = 16'd88;

  localparam int          NUM_FACES  = 4;
  localparam logic [2:0]  NONE_FACE  = 3'd4;
  localparam logic [15:0] CLOSE_MAX  = 16'hFFFF;
  localparam int          CLAMP_IN_W = 40;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] open_threshold;
    logic [15:0] min_clearance;
    logic [15:0] clearance_hysteresis;
    logic [15:0] wall_near_limit;
    logic [15:0] follow_target;
  } rfwt_cfg_t;

  // Classified frame: decisions per face, ready for the stateful back part
  typedef struct packed {
    logic [3:0]        open_set;
    logic [3:0]        open_clr;
    logic [3:0]        close_set;
    logic [3:0]        close_clr;
    logic [3:0][15:0]  close_val;
    logic              wall_any;
    logic [1:0]        wall_face;
    logic signed [16:0] wall_diff;
    logic              follow_any;
    logic [1:0]        follow_face;
    logic signed [16:0] follow_val;
  } rfwt_item_t;

  // Saturate a signed value to -65535..65535
  function automatic logic signed [16:0] clamp_serr(input logic signed [CLAMP_IN_W-1:0] v);
    logic signed [16:0] res;
    if (v > 40'sd65535) begin
      res = 17'sd65535;
    end else if (v < -40'sd65535) begin
      res = -17'sd65535;
    end else begin
      res = v[16:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/rfwt_ifs.sv -----
// Valid/ready channel interfaces for range frames and tracker results.
interface rfwt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_s0;
  logic [15:0] range_s1;
  logic [15:0] range_s2;
  logic [15:0] range_s3;
  logic [15:0] range_s4;
  logic [15:0] range_s5;
  logic [15:0] range_s6;
  logic [15:0] range_s7;
  logic [1:0]  heading_face;

  modport source (output valid, range_s0, range_s1, range_s2, range_s3, range_s4,
                  range_s5, range_s6, range_s7, heading_face, input ready);
  modport sink (input valid, range_s0, range_s1, range_s2, range_s3, range_s4,
                range_s5, range_s6, range_s7, heading_face, output ready);
endinterface

interface rfwt_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         open_mask;
  logic [15:0]        close_err_f0;
  logic [15:0]        close_err_f1;
  logic [15:0]        close_err_f2;
  logic [15:0]        close_err_f3;
  logic signed [16:0] misalign_err;
  logic [2:0]         follow_side;
  logic signed [16:0] follow_err;
  logic [3:0]         close_reset_mask;
  logic               align_reset;
  logic               follow_reset;

  modport source (output valid, open_mask, close_err_f0, close_err_f1, close_err_f2,
                  close_err_f3, misalign_err, follow_side, follow_err, close_reset_mask,
                  align_reset, follow_reset, input ready);
  modport sink (input valid, open_mask, close_err_f0, close_err_f1, close_err_f2,
                close_err_f3, misalign_err, follow_side, follow_err, close_reset_mask,
                align_reset, follow_reset, output ready);
endinterface

// ----- hdl/rfwt_cfg_regs.sv -----
// APB-style configuration register file of the wall tracker.
module rfwt_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rfwt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rfwt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rfwt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output rfwt_pkg::rfwt_cfg_t             cfg
);
  import rfwt_pkg::*;

  rfwt_cfg_t  cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write on the access phase; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_threshold       <= RST_OPEN_THRESHOLD;
      cfg_r.min_clearance        <= RST_MIN_CLEARANCE;
      cfg_r.clearance_hysteresis <= RST_CLEAR_HYST;
      cfg_r.wall_near_limit      <= RST_WALL_NEAR;
      cfg_r.follow_target        <= RST_FOLLOW_TARGET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OPEN_THRESHOLD: cfg_r.open_threshold       <= pwdata[15:0];
        REG_MIN_CLEARANCE:  cfg_r.min_clearance        <= pwdata[15:0];
        REG_CLEAR_HYST:     cfg_r.clearance_hysteresis <= pwdata[15:0];
        REG_WALL_NEAR:      cfg_r.wall_near_limit      <= pwdata[15:0];
        REG_FOLLOW_TARGET:  cfg_r.follow_target        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    unique case (reg_idx)
      REG_OPEN_THRESHOLD: prdata = CFG_DATA_W'(cfg_r.open_threshold);
      REG_MIN_CLEARANCE:  prdata = CFG_DATA_W'(cfg_r.min_clearance);
      REG_CLEAR_HYST:     prdata = CFG_DATA_W'(cfg_r.clearance_hysteresis);
      REG_WALL_NEAR:      prdata = CFG_DATA_W'(cfg_r.wall_near_limit);
      REG_FOLLOW_TARGET:  prdata = CFG_DATA_W'(cfg_r.follow_target);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- hdl/rfwt_front.sv -----
// Front part: accepts a range frame and classifies every face against the registers.
module rfwt_front #(
  parameter int DIST_BITS = 16
) (
  rfwt_in_if.sink                  in_ch,
  input  rfwt_pkg::rfwt_cfg_t      cfg,
  input  logic                     q_full,
  output logic                     push,
  output rfwt_pkg::rfwt_item_t     item
);
  import rfwt_pkg::*;

  localparam int DW = (DIST_BITS > 16) ? DIST_BITS : 16;
  localparam int SW = DW + 1;
  localparam int AW = DW + 3;

  logic [NUM_FACES-1:0][DIST_BITS-1:0] ra;
  logic [NUM_FACES-1:0][DIST_BITS-1:0] rb;
  logic [NUM_FACES-1:0][DW-1:0]        a_w;
  logic [NUM_FACES-1:0][DW-1:0]        b_w;
  logic [NUM_FACES-1:0][SW-1:0]        sum;
  logic [NUM_FACES-1:0]                walled;
  logic [NUM_FACES-1:0][16:0]          diff_c;
  logic [SW-1:0]                       thr2;
  logic [SW-1:0]                       clr_hi;
  logic                                wall_hit;
  logic [1:0]                          wall_sel;
  logic [1:0]                          ccw_face;
  logic [1:0]                          cw_face;
  logic [SW-1:0]                       side_sum;
  logic [AW-1:0]                       t2;
  logic signed [AW-1:0]                d1;
  logic signed [AW-1:0]                half;

  // Accept while the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Mask readings to the distance width
  assign ra[0] = DIST_BITS'(in_ch.range_s0);
  assign rb[0] = DIST_BITS'(in_ch.range_s1);
  assign ra[1] = DIST_BITS'(in_ch.range_s2);
  assign rb[1] = DIST_BITS'(in_ch.range_s3);
  assign ra[2] = DIST_BITS'(in_ch.range_s4);
  assign rb[2] = DIST_BITS'(in_ch.range_s5);
  assign ra[3] = DIST_BITS'(in_ch.range_s6);
  assign rb[3] = DIST_BITS'(in_ch.range_s7);

  assign thr2   = SW'({cfg.open_threshold, 1'b0});
  assign clr_hi = SW'(cfg.min_clearance) + SW'(cfg.clearance_hysteresis);

  // Classify each face
  for (genvar i = 0; i < NUM_FACES; i++) begin : g_face
    logic [DW-1:0]        mn;
    logic [SW-1:0]        clr_lo;
    logic [SW-1:0]        err;
    logic signed [AW-1:0] diff;

    assign a_w[i]  = DW'(ra[i]);
    assign b_w[i]  = DW'(rb[i]);
    assign sum[i]  = SW'(a_w[i]) + SW'(b_w[i]);
    assign mn      = (a_w[i] < b_w[i]) ? a_w[i] : b_w[i];
    assign walled[i] = (a_w[i] < DW'(cfg.wall_near_limit)) &&
                       (b_w[i] < DW'(cfg.wall_near_limit));

    assign item.open_set[i] = sum[i] > thr2;
    assign item.open_clr[i] = sum[i] < thr2;

    assign clr_lo            = SW'(mn) + SW'(cfg.clearance_hysteresis);
    assign item.close_set[i] = clr_lo < SW'(cfg.min_clearance);
    assign item.close_clr[i] = SW'(mn) > clr_hi;
    assign err               = SW'(cfg.min_clearance) - SW'(mn);
    assign item.close_val[i] = (err > SW'(CLOSE_MAX)) ? CLOSE_MAX : err[15:0];

    assign diff      = $signed(AW'(a_w[i])) - $signed(AW'(b_w[i]));
    assign diff_c[i] = clamp_serr(CLAMP_IN_W'(diff));
  end

  // Pick the first walled face for alignment
  always_comb begin
    wall_hit = 1'b1;
    wall_sel = 2'd0;
    priority if (walled[0]) begin
      wall_sel = 2'd0;
    end else if (walled[1]) begin
      wall_sel = 2'd1;
    end else if (walled[2]) begin
      wall_sel = 2'd2;
    end else if (walled[3]) begin
      wall_sel = 2'd3;
    end else begin
      wall_hit = 1'b0;
    end
  end
  assign item.wall_any  = wall_hit;
  assign item.wall_face = wall_sel;
  assign item.wall_diff = $signed(diff_c[wall_sel]);

  // Choose the follow side: left if walled, else right
  assign ccw_face = in_ch.heading_face + 2'd1;
  assign cw_face  = in_ch.heading_face + 2'd3;
  assign item.follow_any  = walled[ccw_face] || walled[cw_face];
  assign item.follow_face = walled[ccw_face] ? ccw_face : cw_face;

  // Target minus side average, half rounded upward
  assign side_sum = sum[item.follow_face];
  assign t2       = AW'({cfg.follow_target, 1'b0});
  assign d1       = $signed(t2 - AW'(side_sum) + AW'(1));
  assign half     = d1 >>> 1;
  assign item.follow_val = clamp_serr(CLAMP_IN_W'(half));

endmodule

// ----- hdl/rfwt_queue.sv -----
// Two-entry queue of classified frames between front and back.
module rfwt_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rfwt_pkg::rfwt_item_t wr_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output rfwt_pkg::rfwt_item_t rd_item
);
  import rfwt_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rfwt_item_t    slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = count_r == CW'(QUEUE_DEPTH);
  assign valid   = count_r != '0;
  assign rd_item = slot_r[rd_ptr_r];

  // Store the pushed frame
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      priority if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end else begin
        count_r <= count_r;
      end
    end
  end

endmodule

// ----- hdl/rfwt_back.sv -----
// Back part: applies classified frames to the tracker state and holds the result.
module rfwt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  rfwt_pkg::rfwt_item_t q_item,
  output logic                 pop,
  rfwt_out_if.source           out_ch
);
  import rfwt_pkg::*;

  logic                          out_valid_r;
  logic [3:0]                    open_bits_r,   open_bits_nxt;
  logic [NUM_FACES-1:0][15:0]    close_errs_r,  close_errs_nxt;
  logic signed [16:0]            misalign_r,    misalign_nxt;
  logic [2:0]                    tracked_r,     tracked_nxt;
  logic [2:0]                    last_follow_r, last_follow_nxt;
  logic signed [16:0]            follow_err_r,  follow_err_nxt;
  logic [2:0]                    side_r,        side_nxt;
  logic [3:0]                    rmask_r;
  logic                          align_rst_r,   align_rst_nxt;
  logic                          follow_rst_r,  follow_rst_nxt;

  // Take the next frame when the result slot is free or being drained
  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  // Work out the state after this frame
  always_comb begin
    open_bits_nxt = (open_bits_r | q_item.open_set) & ~q_item.open_clr;

    for (int i = 0; i < NUM_FACES; i++) begin
      priority if (q_item.close_set[i]) begin
        close_errs_nxt[i] = q_item.close_val[i];
      end else if (q_item.close_clr[i]) begin
        close_errs_nxt[i] = '0;
      end else begin
        close_errs_nxt[i] = close_errs_r[i];
      end
    end

    if (q_item.wall_any) begin
      align_rst_nxt = tracked_r != {1'b0, q_item.wall_face};
      tracked_nxt   = {1'b0, q_item.wall_face};
      misalign_nxt  = q_item.wall_diff;
    end else begin
      align_rst_nxt = 1'b1;
      tracked_nxt   = tracked_r;
      misalign_nxt  = '0;
    end

    if (q_item.follow_any) begin
      side_nxt        = {1'b0, q_item.follow_face};
      follow_rst_nxt  = last_follow_r != {1'b0, q_item.follow_face};
      last_follow_nxt = {1'b0, q_item.follow_face};
      follow_err_nxt  = q_item.follow_val;
    end else begin
      side_nxt        = NONE_FACE;
      follow_rst_nxt  = 1'b1;
      last_follow_nxt = last_follow_r;
      follow_err_nxt  = follow_err_r;
    end
  end

  // Hold state and result; the state registers double as result fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      open_bits_r   <= '0;
      close_errs_r  <= '0;
      misalign_r    <= '0;
      tracked_r     <= NONE_FACE;
      last_follow_r <= NONE_FACE;
      follow_err_r  <= '0;
      side_r        <= NONE_FACE;
      rmask_r       <= '0;
      align_rst_r   <= 1'b0;
      follow_rst_r  <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r   <= 1'b1;
        open_bits_r   <= open_bits_nxt;
        close_errs_r  <= close_errs_nxt;
        misalign_r    <= misalign_nxt;
        tracked_r     <= tracked_nxt;
        last_follow_r <= last_follow_nxt;
        follow_err_r  <= follow_err_nxt;
        side_r        <= side_nxt;
        rmask_r       <= q_item.close_clr;
        align_rst_r   <= align_rst_nxt;
        follow_rst_r  <= follow_rst_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.open_mask        = open_bits_r;
  assign out_ch.close_err_f0     = close_errs_r[0];
  assign out_ch.close_err_f1     = close_errs_r[1];
  assign out_ch.close_err_f2     = close_errs_r[2];
  assign out_ch.close_err_f3     = close_errs_r[3];
  assign out_ch.misalign_err     = misalign_r;
  assign out_ch.follow_side      = side_r;
  assign out_ch.follow_err       = follow_err_r;
  assign out_ch.close_reset_mask = rmask_r;
  assign out_ch.align_reset      = align_rst_r;
  assign out_ch.follow_reset     = follow_rst_r;

endmodule

// ----- hdl/range_frame_wall_tracker.sv -----
// Top level of the range frame wall tracker: registers, front, queue and back.
//
//  Channel   Direction  Transfer when            Carries
//  in_ch     sink       valid && ready           eight ranges and heading
//  out_ch    source     valid && ready           masks, errors, reset pulses
//  psel ..   APB slave  psel&penable&pwrite      five 16-bit registers
//
// One frame per cycle is sustained while out_ch does not stall; a result is offered after its input
// transfer has gone through a queue write and then a result register load.
// Synchronous active-low reset clears all tracker state and restores registers.
// An output stall fills the two-entry queue before in_ch.ready drops.
module range_frame_wall_tracker #(
  parameter int DIST_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rfwt_in_if.sink                         in_ch,
  rfwt_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rfwt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rfwt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rfwt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import rfwt_pkg::*;

  rfwt_cfg_t  cfg;
  rfwt_item_t wr_item;
  rfwt_item_t rd_item;
  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;

  rfwt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfwt_front #(.DIST_BITS(DIST_BITS)) u_front (
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .item   (wr_item)
  );

  rfwt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (pop),
    .valid   (q_valid),
    .rd_item (rd_item)
  );

  rfwt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (rd_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the range frame wall tracker: directed and random frames.
module tb;
  import rfwt_pkg::*;

  // Register indexes past the five real registers; writes there are ignored
  localparam logic [2:0] REG_SPARE = 3'd5;

  typedef struct packed {
    logic [7:0][15:0] rng;
    logic [1:0]       heading;
  } range_frame_t;

  typedef struct packed {
    logic [3:0]         open_mask;
    logic [3:0][15:0]   close_err;
    logic signed [16:0] misalign_err;
    logic [2:0]         follow_side;
    logic signed [16:0] follow_err;
    logic [3:0]         close_reset_mask;
    logic               align_reset;
    logic               follow_reset;
  } tracker_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rfwt_in_if  in_ch ();
  rfwt_out_if out_ch ();

  range_frame_wall_tracker dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Tracker settings and state as the block should hold them
  logic [15:0]        cfg_open_thr;
  logic [15:0]        cfg_min_clr;
  logic [15:0]        cfg_hyst;
  logic [15:0]        cfg_wall;
  logic [15:0]        cfg_target;
  logic [3:0]         trk_open;
  logic [3:0][15:0]   trk_close;
  logic signed [16:0] trk_misalign;
  logic [2:0]         trk_align_face;
  logic [2:0]         trk_follow_face;
  logic signed [16:0] trk_follow_hold;

  tracker_result_t pending_results[$];

  int src_idle_pct;
  int snk_idle_pct;
  int sink_hold;
  int fail_count;
  int frames_sent;
  int results_checked;
  int reg_writes;
  int input_stalls;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    #1_600_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result-side ready: random stalls, or a counted hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic logic signed [16:0] sat17(int v);
    if (v > 65535) return 17'sd65535;
    if (v < -65535) return -17'sd65535;
    return 17'(v);
  endfunction

  function automatic void reset_tracker();
    cfg_open_thr    = RST_OPEN_THRESHOLD;
    cfg_min_clr     = RST_MIN_CLEARANCE;
    cfg_hyst        = RST_CLEAR_HYST;
    cfg_wall        = RST_WALL_NEAR;
    cfg_target      = RST_FOLLOW_TARGET;
    trk_open        = '0;
    trk_close       = '0;
    trk_misalign    = '0;
    trk_align_face  = NONE_FACE;
    trk_follow_face = NONE_FACE;
    trk_follow_hold = '0;
  endfunction

  // Advance the tracker state by one frame and return the result it gives
  function automatic tracker_result_t track_frame(range_frame_t f);
    int               a[4];
    int               b[4];
    bit               walled[4];
    bit               taken;
    logic [1:0]       left_f;
    logic [1:0]       right_f;
    logic [2:0]       side;
    int               d;
    int               s;
    int               m;
    tracker_result_t  r;
    r      = '0;
    taken  = 1'b0;
    side   = NONE_FACE;
    for (int i = 0; i < NUM_FACES; i++) begin
      a[i]      = int'(f.rng[2*i]);
      b[i]      = int'(f.rng[2*i+1]);
      walled[i] = (a[i] < int'(cfg_wall)) && (b[i] < int'(cfg_wall));
    end

    // Side wall: left preferred, then right
    left_f  = f.heading + 2'd1;
    right_f = f.heading + 2'd3;
    if (walled[left_f]) side = {1'b0, left_f};
    else if (walled[right_f]) side = {1'b0, right_f};
    r.follow_reset = 1'b1;
    if (side != NONE_FACE) begin
      d = 2 * int'(cfg_target) - a[side[1:0]] - b[side[1:0]];
      r.follow_reset  = (trk_follow_face != side);
      // halve, with the half case going up
      trk_follow_hold = sat17((d + 1) >>> 1);
      trk_follow_face = side;
    end

    for (int i = 0; i < NUM_FACES; i++) begin
      s = a[i] + b[i];
      m = (a[i] < b[i]) ? a[i] : b[i];
      if (walled[i] && (!taken || trk_align_face == i)) begin
        if (!taken && trk_align_face != i) begin
          r.align_reset  = 1'b1;
          trk_align_face = 3'(i);
        end
        trk_misalign = sat17(a[i] - b[i]);
        taken = 1'b1;
      end
      if (s > 2 * int'(cfg_open_thr)) trk_open[i] = 1'b1;
      else if (s < 2 * int'(cfg_open_thr)) trk_open[i] = 1'b0;
      if (m + int'(cfg_hyst) < int'(cfg_min_clr)) begin
        trk_close[i] = 16'(int'(cfg_min_clr) - m);
      end else if (m > int'(cfg_min_clr) + int'(cfg_hyst)) begin
        trk_close[i] = '0;
        r.close_reset_mask[i] = 1'b1;
      end
    end
    if (!taken) begin
      trk_misalign  = '0;
      r.align_reset = 1'b1;
    end

    r.open_mask    = trk_open;
    r.close_err    = trk_close;
    r.misalign_err = trk_misalign;
    r.follow_side  = side;
    r.follow_err   = trk_follow_hold;
    return r;
  endfunction

  function automatic range_frame_t frame_of(logic [15:0] r0, logic [15:0] r1, logic [15:0] r2,
                                            logic [15:0] r3, logic [15:0] r4, logic [15:0] r5,
                                            logic [15:0] r6, logic [15:0] r7, logic [1:0] hd);
    range_frame_t f;
    f.rng     = {r7, r6, r5, r4, r3, r2, r1, r0};
    f.heading = hd;
    return f;
  endfunction

  // Reading biased toward the current thresholds and the field extremes
  function automatic logic [15:0] pick_range();
    int          v;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      v = $urandom_range(1) ? 65535 : 0;
    end else if (sel < 35) begin
      v = int'($urandom_range(65535));
    end else begin
      case ($urandom_range(4))
        0:       v = int'(cfg_open_thr);
        1:       v = int'(cfg_min_clr) - int'(cfg_hyst);
        2:       v = int'(cfg_min_clr) + int'(cfg_hyst);
        3:       v = int'(cfg_wall);
        default: v = int'(cfg_target);
      endcase
      v = v + int'($urandom_range(40)) - 20;
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic range_frame_t random_frame();
    range_frame_t f;
    int           pair;
    for (int i = 0; i < 8; i++) f.rng[i] = pick_range();
    // Sometimes land a face's sum exactly on the open threshold
    for (int i = 0; i < NUM_FACES; i++) begin
      if ($urandom_range(6) == 0) begin
        pair = 2 * int'(cfg_open_thr) - int'(f.rng[2*i]);
        if (pair >= 0 && pair <= 65535) f.rng[2*i+1] = 16'(pair);
      end
    end
    f.heading = 2'($urandom_range(3));
    return f;
  endfunction

  function automatic logic [15:0] pick_setting();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(400));
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    tracker_result_t  want;
    logic [3:0][15:0] got_close;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no frame outstanding");
        fail_count++;
      end else begin
        want      = pending_results.pop_front();
        got_close = {out_ch.close_err_f3, out_ch.close_err_f2,
                     out_ch.close_err_f1, out_ch.close_err_f0};
        results_checked++;
        check_field("open_mask", want.open_mask, out_ch.open_mask);
        for (int i = 0; i < NUM_FACES; i++)
          check_field($sformatf("close_err_f%0d", i), want.close_err[i], got_close[i]);
        check_field("misalign_err", want.misalign_err, out_ch.misalign_err);
        check_field("follow_side", want.follow_side, out_ch.follow_side);
        check_field("follow_err", want.follow_err, out_ch.follow_err);
        check_field("close_reset_mask", want.close_reset_mask, out_ch.close_reset_mask);
        check_field("align_reset", want.align_reset, out_ch.align_reset);
        check_field("follow_reset", want.follow_reset, out_ch.follow_reset);
      end
    end
  end

  // Offer one frame, idling first at random, and hold it until the transfer
  task automatic send_frame(range_frame_t f);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.range_s0     <= f.rng[0];
    in_ch.range_s1     <= f.rng[1];
    in_ch.range_s2     <= f.rng[2];
    in_ch.range_s3     <= f.rng[3];
    in_ch.range_s4     <= f.rng[4];
    in_ch.range_s5     <= f.rng[5];
    in_ch.range_s6     <= f.rng[6];
    in_ch.range_s7     <= f.rng[7];
    in_ch.heading_face <= f.heading;
    do begin
      @(posedge clk);
      if (!in_ch.ready) input_stalls++;
    end while (!in_ch.ready);
    pending_results.push_back(track_frame(f));
    frames_sent++;
  endtask

  // Drop valid and wait until every outstanding result has been seen
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Register write: setup then access phase; only call while the block is idle
  task automatic cfg_write(logic [2:0] idx, logic [15:0] value);
    logic [31:0] word;
    word = {16'($urandom), value};
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    case (idx)
      REG_OPEN_THRESHOLD: cfg_open_thr = value;
      REG_MIN_CLEARANCE:  cfg_min_clr  = value;
      REG_CLEAR_HYST:     cfg_hyst     = value;
      REG_WALL_NEAR:      cfg_wall     = value;
      REG_FOLLOW_TARGET:  cfg_target   = value;
      default: ;
    endcase
  endtask

  task automatic restore_defaults();
    cfg_write(REG_OPEN_THRESHOLD, RST_OPEN_THRESHOLD);
    cfg_write(REG_MIN_CLEARANCE, RST_MIN_CLEARANCE);
    cfg_write(REG_CLEAR_HYST, RST_CLEAR_HYST);
    cfg_write(REG_WALL_NEAR, RST_WALL_NEAR);
    cfg_write(REG_FOLLOW_TARGET, RST_FOLLOW_TARGET);
  endtask

  task automatic set_idling(int src_pct, int snk_pct);
    @(negedge clk);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    @(posedge clk);
  endtask

  // Open bits: set above, clear below, hold on an exact threshold sum
  task automatic test_open_faces();
    send_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 2'd0));
    send_frame(frame_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3));
    send_frame(frame_of(192, 192, 192, 192, 192, 192, 192, 192, 2'd1));
    send_frame(frame_of(200, 184, 0, 383, 385, 0, 16'hFFFF, 0, 2'd2));
  endtask

  // Closeness: error inside the low band, clear and pulse above, hold between
  task automatic test_clearance_band();
    send_frame(frame_of(51, 200, 52, 52, 76, 300, 77, 77, 2'd2));
    send_frame(frame_of(0, 16'hFFFF, 64, 64, 16'hFFFF, 16'hFFFF, 40, 41, 2'd0));
    send_frame(frame_of(51, 200, 52, 52, 76, 300, 77, 77, 2'd2));
  endtask

  // Tracked wall face: moves to the first walled face, zero when none
  task automatic test_wall_alignment();
    send_frame(frame_of(300, 300, 10, 150, 150, 10, 300, 300, 2'd0));
    send_frame(frame_of(159, 0, 10, 150, 150, 10, 300, 300, 2'd1));
    send_frame(frame_of(160, 0, 10, 150, 150, 10, 300, 300, 2'd2));
    send_frame(frame_of(160, 160, 160, 160, 160, 160, 160, 160, 2'd3));
  endtask

  // Follow side: left first, then right, none holds; odd sums round up
  task automatic test_follow_side();
    send_frame(frame_of(300, 300, 50, 51, 300, 300, 300, 300, 2'd0));
    send_frame(frame_of(300, 300, 50, 51, 300, 300, 300, 300, 2'd0));
    send_frame(frame_of(300, 300, 300, 300, 300, 300, 100, 101, 2'd0));
    send_frame(frame_of(10, 20, 300, 300, 10, 20, 300, 300, 2'd0));
    send_frame(frame_of(300, 300, 300, 300, 7, 8, 300, 300, 2'd3));
  endtask

  // Registers at their extremes, plus writes to unused indexes
  task automatic test_register_extremes();
    wait_results();
    cfg_write(REG_WALL_NEAR, 16'hFFFF);
    cfg_write(REG_FOLLOW_TARGET, 16'hFFFF);
    cfg_write(REG_OPEN_THRESHOLD, 16'h0000);
    cfg_write(REG_MIN_CLEARANCE, 16'hFFFF);
    cfg_write(REG_CLEAR_HYST, 16'h0000);
    send_frame(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 2'd1));
    send_frame(frame_of(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE,
                        16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 2'd2));
    wait_results();
    cfg_write(REG_FOLLOW_TARGET, 16'h0000);
    cfg_write(REG_OPEN_THRESHOLD, 16'hFFFF);
    cfg_write(REG_SPARE + 3'd2, 16'h1234);
    send_frame(frame_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3));
    send_frame(frame_of(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE,
                        16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 2'd0));
    wait_results();
    cfg_write(REG_MIN_CLEARANCE, 16'h0000);
    cfg_write(REG_CLEAR_HYST, 16'hFFFF);
    cfg_write(REG_SPARE, 16'hFFFF);
    send_frame(frame_of(0, 16'hFFFF, 1, 2, 16'h8000, 16'h7FFF, 16'hFFFF, 0, 2'd1));
    wait_results();
    restore_defaults();
  endtask

  // Random frames in chunks, re-tuning a couple of registers between chunks
  task automatic test_random_frames(int chunks);
    for (int c = 0; c < chunks; c++) begin
      wait_results();
      repeat (2) cfg_write(3'($urandom_range(4)), pick_setting());
      if ($urandom_range(3) == 0) cfg_write(REG_SPARE + 3'($urandom_range(2)), pick_setting());
      repeat (100) send_frame(random_frame());
    end
  endtask

  // Hold the result side off long enough for the block to stall its input
  task automatic test_output_backlog();
    @(negedge clk);
    sink_hold = 60;
    @(posedge clk);
    repeat (30) send_frame(random_frame());
  endtask

  // Stop offering frames until everything outstanding has come out
  task automatic test_sender_pause();
    repeat (12) send_frame(random_frame());
    wait_results();
    repeat (12) send_frame(random_frame());
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.range_s0     = '0;
    in_ch.range_s1     = '0;
    in_ch.range_s2     = '0;
    in_ch.range_s3     = '0;
    in_ch.range_s4     = '0;
    in_ch.range_s5     = '0;
    in_ch.range_s6     = '0;
    in_ch.range_s7     = '0;
    in_ch.heading_face = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    src_idle_pct       = 0;
    snk_idle_pct       = 0;
    sink_hold          = 0;
    fail_count         = 0;
    frames_sent        = 0;
    results_checked    = 0;
    reg_writes         = 0;
    input_stalls       = 0;
    reset_tracker();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles lightly, receiver heavily
    set_idling(20, 72);
    test_open_faces();
    test_clearance_band();
    test_wall_alignment();
    test_follow_side();
    test_register_extremes();
    test_random_frames(4);

    // The other way round
    wait_results();
    set_idling(72, 20);
    test_sender_pause();
    test_random_frames(4);

    // Back to back on both sides
    wait_results();
    set_idling(0, 0);
    test_output_backlog();
    test_random_frames(4);

    wait_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d frames across %0d register writes.",
             results_checked, frames_sent, reg_writes);
    $display("Idling mixes and an output backlog gave %0d input stall cycles.", input_stalls);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
